FILE: hw/rtl/rsas_pkg.sv
// Shared types and constants of the rotated sorted array search block.
// No dependencies; imported by every module of the block but rsas_ram.
package rsas_pkg;

   localparam int DEPTH_DEFAULT = 1024;
   localparam int DATA_W        = 32;
   localparam int OP_W          = 2;
   localparam int POS_W         = 10;

   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
   localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

   typedef enum logic [2:0] {
      SEQ_IDLE,
      SEQ_LAST,
      SEQ_CMP,
      SEQ_ISSUE,
      SEQ_FINAL,
      SEQ_DONE
   } seq_state_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic             found;
      logic [POS_W-1:0] position;
   } seq_status_type;

endpackage

FILE: hw/rtl/rotated_sorted_array_search.sv
// Top level of the rotated sorted array search block.
// Depends on rsas_pkg, rsas_ram and rsas_seq.
//
// Usage:
//  req_ channel carries one item: req_opcode (clear, append, search) and req_value.
//  rsp_ channel returns one item for each append and each search:
//  rsp_found, rsp_position and rsp_overflow. Clear and the unused opcode
//  return nothing.
//  An append writes the element RAM and loads its item into the output register
//  at the accept edge; an append to a full array is dropped with rsp_overflow
//  set. A search reads the last element, then probes with one RAM read and
//  one compare each, and ends with one read at the low bound if that lies
//  below the count. An empty array answers with no probe.
//  One item is worked on at a time; req_stall is high while a search runs
//  or while a finished item is held by rsp_stall.
//  Reset clears the element count and the control state; the RAM is not
//  cleared, as only entries below the count are ever used.
module rotated_sorted_array_search
   import rsas_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W  = $clog2(DEPTH + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [OP_W-1:0]          req_opcode,
   input  logic signed [DATA_W-1:0] req_value,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_found,
   output logic [POS_W-1:0]         rsp_position,
   output logic                     rsp_overflow
);

   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_found_ff, rsp_found_in;
   logic [POS_W-1:0]  rsp_position_ff, rsp_position_in;
   logic              rsp_overflow_ff, rsp_overflow_in;

   logic              accept;
   logic              full;
   logic              slot_free;
   logic              wr_en;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [DATA_W-1:0] rd_data;
   logic              seq_start;
   logic              seq_ack;
   seq_status_type    seq_status;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign req_stall = seq_status.busy || !slot_free;
   assign accept    = req_valid && !req_stall;
   assign full      = count_ff == CNT_W'(DEPTH);
   assign wr_en     = accept && (req_opcode == OP_APPEND) && !full;
   assign seq_start = accept && (req_opcode == OP_SEARCH);
   assign seq_ack   = seq_status.done && slot_free;

   rsas_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (req_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rsas_seq #(
      .DEPTH (DEPTH)
   ) u_seq (
      .clock   (clock),
      .reset   (reset),
      .start   (seq_start),
      .target  (req_value),
      .count   (count_ff),
      .ack     (seq_ack),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .status  (seq_status)
   );

   always_comb begin
      count_in        = count_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_found_in    = rsp_found_ff;
      rsp_position_in = rsp_position_ff;
      rsp_overflow_in = rsp_overflow_ff;
      priority if (accept && (req_opcode == OP_CLEAR)) begin
         count_in = '0;
      end else if (accept && (req_opcode == OP_APPEND)) begin
         if (!full) begin
            count_in = count_ff + CNT_W'(1);
         end
         rsp_valid_in    = 1'b1;
         rsp_found_in    = 1'b0;
         rsp_position_in = '0;
         rsp_overflow_in = full;
      end else if (seq_ack) begin
         rsp_valid_in    = 1'b1;
         rsp_found_in    = seq_status.found;
         rsp_position_in = seq_status.position;
         rsp_overflow_in = 1'b0;
      end else begin
         count_in = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_found_ff    <= rsp_found_in;
      rsp_position_ff <= rsp_position_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_found    = rsp_found_ff;
   assign rsp_position = rsp_position_ff;
   assign rsp_overflow = rsp_overflow_ff;

endmodule

FILE: hw/rtl/rsas_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rsas_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/rsas_seq.sv
// Search sequencer: bounds, probe address and predicate over the element RAM.
// Depends on rsas_pkg; reads through the RAM port of the top level.
module rsas_seq
   import rsas_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEFAULT,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W  = $clog2(DEPTH + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [DATA_W-1:0] target,
   input  logic [CNT_W-1:0]         count,
   input  logic                     ack,
   output logic                     rd_en,
   output logic [ADDR_W-1:0]        rd_addr,
   input  logic [DATA_W-1:0]        rd_data,
   output seq_status_type           status
);

   seq_state_type state_ff, state_in;

   logic signed [DATA_W-1:0] target_ff, target_in;
   logic signed [DATA_W-1:0] last_ff, last_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [CNT_W-1:0]         lo_ff, lo_in;
   logic [CNT_W-1:0]         hip1_ff, hip1_in;
   logic [ADDR_W-1:0]        mid_ff, mid_in;
   logic                     found_ff, found_in;

   logic signed [DATA_W-1:0] elem;
   logic [CNT_W:0]           mid_sum;
   logic [ADDR_W-1:0]        mid_next;
   logic [CNT_W-1:0]         count_m1;
   logic                     bounds_open;
   logic                     lo_in_range;
   logic                     go_left;
   logic [CNT_W+POS_W-1:0]   lo_wide;

   assign elem        = $signed(rd_data);
   assign mid_sum     = ({1'b0, lo_ff} + {1'b0, hip1_ff} - (CNT_W+1)'(1)) >> 1;
   assign mid_next    = mid_sum[ADDR_W-1:0];
   assign count_m1    = count - CNT_W'(1);
   assign bounds_open = lo_ff < hip1_ff;
   assign lo_in_range = lo_ff < count_ff;
   assign lo_wide     = {{POS_W{1'b0}}, lo_ff};

   // true when the target lies at or left of the probe
   always_comb begin
      if (elem > last_ff) begin
         go_left = (target_ff <= elem) && (target_ff > last_ff);
      end else begin
         go_left = (target_ff <= elem) || (target_ff > last_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SEQ_IDLE;
      end else begin
         state_ff <= state_in;
      end
      target_ff <= target_in;
      last_ff   <= last_in;
      count_ff  <= count_in;
      lo_ff     <= lo_in;
      hip1_ff   <= hip1_in;
      mid_ff    <= mid_in;
      found_ff  <= found_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               state_in = (count == '0) ? SEQ_DONE : SEQ_LAST;
            end
         end
         SEQ_LAST:  state_in = SEQ_CMP;
         SEQ_CMP:   state_in = SEQ_ISSUE;
         SEQ_ISSUE: begin
            priority if (bounds_open) begin
               state_in = SEQ_CMP;
            end else if (lo_in_range) begin
               state_in = SEQ_FINAL;
            end else begin
               state_in = SEQ_DONE;
            end
         end
         SEQ_FINAL: state_in = SEQ_DONE;
         SEQ_DONE: begin
            if (ack) begin
               state_in = SEQ_IDLE;
            end
         end
         default:   state_in = SEQ_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = mid_next;
      unique case (state_ff)
         SEQ_IDLE: begin
            rd_en   = start;
            rd_addr = count_m1[ADDR_W-1:0];
         end
         SEQ_LAST:  rd_en = 1'b1;
         SEQ_ISSUE: begin
            rd_en = bounds_open || lo_in_range;
            if (!bounds_open) begin
               rd_addr = lo_ff[ADDR_W-1:0];
            end
         end
         default:   rd_en = 1'b0;
      endcase
      status.busy     = state_ff != SEQ_IDLE;
      status.done     = state_ff == SEQ_DONE;
      status.found    = found_ff;
      status.position = found_ff ? lo_wide[POS_W-1:0] : '0;
   end

   // datapath
   always_comb begin
      target_in = target_ff;
      last_in   = last_ff;
      count_in  = count_ff;
      lo_in     = lo_ff;
      hip1_in   = hip1_ff;
      mid_in    = mid_ff;
      found_in  = found_ff;
      unique case (state_ff)
         SEQ_IDLE: begin
            if (start) begin
               target_in = target;
               count_in  = count;
               lo_in     = '0;
               hip1_in   = count;
               found_in  = 1'b0;
            end
         end
         SEQ_LAST: begin
            last_in = elem;
            mid_in  = mid_next;
         end
         SEQ_CMP: begin
            if (go_left) begin
               hip1_in = CNT_W'(mid_ff);
            end else begin
               lo_in = CNT_W'(mid_ff) + CNT_W'(1);
            end
         end
         SEQ_ISSUE: mid_in = mid_next;
         SEQ_FINAL: found_in = elem == target_ff;
         default: begin
            found_in = found_ff;
         end
      endcase
   end

endmodule

FILE: hw/rtl/rsas_checker.sv
// Port-level assertions for rotated_sorted_array_search, bound to the top level.
// Depends on rsas_pkg and rotated_sorted_array_search.
module rsas_checker
   import rsas_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     req_valid,
   input logic                     req_stall,
   input logic [OP_W-1:0]          req_opcode,
   input logic                     rsp_valid,
   input logic                     rsp_stall,
   input logic                     rsp_found,
   input logic [POS_W-1:0]         rsp_position,
   input logic                     rsp_overflow
);

   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_found)
         && $stable(rsp_position) && $stable(rsp_overflow))
      else $error("stalled rsp item changed");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid after reset");

   a_found_xor_overflow: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_found && rsp_overflow))
      else $error("found and overflow together");

   a_miss_position: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_position == '0)
      else $error("position set without a hit");

   a_append_answers: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_opcode == OP_APPEND) |=> rsp_valid && !rsp_found)
      else $error("append item not answered");

endmodule

bind rotated_sorted_array_search rsas_checker u_rsas_checker (.*);

FILE: tb/tb_top.sv
// Self-checking testbench for rotated_sorted_array_search: a scoreboard class predicts
// every answer, and plain tasks drive clear, append, search and unused items with random idling.
// Depends on rsas_pkg and the rotated_sorted_array_search RTL.
`timescale 1ns / 100ps

module tb_top;
   import rsas_pkg::*;

   localparam int                TB_DEPTH   = DEPTH_DEFAULT;
   localparam logic [OP_W-1:0]   OP_UNUSED  = 2'd3;
   localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
   localparam int KIND_ROTATED  = 0;
   localparam int KIND_DENSE    = 1;
   localparam int KIND_UNSORTED = 2;
   localparam int KIND_NO_CLEAR = 3;
   localparam int HOLD_CYCLES   = 300;

   typedef struct packed {
      logic             found;
      logic [POS_W-1:0] position;
      logic             overflow;
   } answer_type;

   class rsas_scoreboard;
      logic signed [DATA_W-1:0] element_copy [TB_DEPTH];
      int                       element_total;
      answer_type               pending_answers [$];
      int                       errors;

      function int pending();
         return pending_answers.size();
      endfunction

      function answer_type locate_target(logic signed [DATA_W-1:0] target);
         answer_type               ans;
         int                       lo;
         int                       hi;
         int                       mid;
         int                       n;
         bit                       go_left;
         logic signed [DATA_W-1:0] mv;
         logic signed [DATA_W-1:0] lv;
         n  = element_total;
         lo = 0;
         hi = n - 1;
         while (lo <= hi) begin
            mid = (lo + hi) / 2;
            mv  = element_copy[mid];
            lv  = element_copy[n - 1];
            if (mv > lv) begin
               go_left = (target <= mv) && (target > lv);
            end else begin
               go_left = (target <= mv) || (target > lv);
            end
            if (go_left) begin
               hi = mid - 1;
            end else begin
               lo = mid + 1;
            end
         end
         ans = '0;
         if (lo < n && element_copy[lo] == target) begin
            ans.found    = 1'b1;
            ans.position = lo[POS_W-1:0];
         end
         return ans;
      endfunction

      function void note_request(logic [OP_W-1:0] op, logic signed [DATA_W-1:0] value);
         answer_type ans;
         ans = '0;
         case (op)
            OP_CLEAR: begin
               element_total = 0;
            end
            OP_APPEND: begin
               if (element_total < TB_DEPTH) begin
                  element_copy[element_total] = value;
                  element_total++;
               end else begin
                  ans.overflow = 1'b1;
               end
               pending_answers.push_back(ans);
            end
            OP_SEARCH: begin
               pending_answers.push_back(locate_target(value));
            end
            default: ;
         endcase
      endfunction

      function void check_answer(logic f, logic [POS_W-1:0] p, logic o);
         answer_type want;
         if (pending_answers.size() == 0) begin
            $display("%0t: unexpected item, found=%0b position=%0d overflow=%0b",
                     $time, f, p, o);
            errors++;
            return;
         end
         want = pending_answers.pop_front();
         if (f !== want.found) begin
            $display("%0t: found mismatch, expected %0b, actual %0b", $time, want.found, f);
            errors++;
         end
         if (p !== want.position) begin
            $display("%0t: position mismatch, expected %0d, actual %0d",
                     $time, want.position, p);
            errors++;
         end
         if (o !== want.overflow) begin
            $display("%0t: overflow mismatch, expected %0b, actual %0b",
                     $time, want.overflow, o);
            errors++;
         end
      endfunction
   endclass

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_valid  = 1'b0;
   logic                     req_stall;
   logic [OP_W-1:0]          req_opcode = '0;
   logic signed [DATA_W-1:0] req_value  = '0;
   logic                     rsp_valid;
   logic                     rsp_stall  = 1'b0;
   logic                     rsp_found;
   logic [POS_W-1:0]         rsp_position;
   logic                     rsp_overflow;

   rsas_scoreboard sb;
   bit             calm;
   bit             hold_req;
   int             sent;

   rotated_sorted_array_search dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_opcode   (req_opcode),
      .req_value    (req_value),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_found    (rsp_found),
      .rsp_position (rsp_position),
      .rsp_overflow (rsp_overflow)
   );

   always #5 clock = ~clock;

   initial begin
      #8000000;
      $display("rotated_sorted_array_search test failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_answer(rsp_found, rsp_position, rsp_overflow);
      end
   end

   // receiver: random stalls, one long hold-off on request
   initial begin
      bit st;
      int len;
      int r;
      forever begin
         if (hold_req) begin
            hold_req = 1'b0;
            st       = 1'b1;
            len      = HOLD_CYCLES;
         end else if (calm) begin
            st  = 1'b0;
            len = 1;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
               st  = 1'b0;
               len = $urandom_range(1, 6);
            end else if (r < 90) begin
               st  = 1'b1;
               len = $urandom_range(1, 3);
            end else begin
               st  = 1'b1;
               len = $urandom_range(8, 40);
            end
         end
         @(negedge clock);
         rsp_stall <= st;
         repeat (len - 1) @(negedge clock);
      end
   end

   function automatic int idle_gap();
      int r;
      if (calm) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   task automatic push_item(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] val);
      int gap;
      gap = idle_gap();
      repeat (gap) begin
         @(negedge clock);
         req_valid  <= 1'b0;
         req_opcode <= OP_W'($urandom);
         req_value  <= $urandom;
      end
      @(negedge clock);
      req_valid  <= 1'b1;
      req_opcode <= op;
      req_value  <= val;
      do @(posedge clock); while (req_stall);
      sb.note_request(op, val);
      if (op != OP_UNUSED) sent++;
   endtask

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic run_sequence(input int n, input int kind, input int searches);
      logic signed [DATA_W-1:0] sorted_vals [$];
      logic signed [DATA_W-1:0] arr [$];
      logic signed [DATA_W-1:0] tgt;
      longint                   v;
      longint                   maxstep;
      int                       rot;
      int                       r;
      if (kind == KIND_UNSORTED) begin
         for (int i = 0; i < n; i++) begin
            if ($urandom_range(0, 1)) arr.push_back($urandom);
            else arr.push_back($urandom_range(0, 7));
         end
      end else if (n > 0) begin
         if (kind == KIND_DENSE) begin
            maxstep = 3;
            v = -64'sd2147483648 + longint'($urandom_range(0, 32'hFFFF_FFFF - 3 * n - 1));
         end else begin
            maxstep = 64'sd4294967296 / (n + 1);
            v = -64'sd2147483648 + longint'($urandom_range(0, 32'(maxstep - 1)));
         end
         for (int i = 0; i < n; i++) begin
            if (i > 0) v += longint'($urandom_range(1, 32'(maxstep)));
            sorted_vals.push_back(v[DATA_W-1:0]);
         end
         if ($urandom_range(0, 3) == 0) sorted_vals[0] = WORD_MIN;
         if ($urandom_range(0, 3) == 0) sorted_vals[n-1] = WORD_MAX;
         rot = $urandom_range(0, n - 1);
         for (int i = 0; i < n; i++) arr.push_back(sorted_vals[(i + rot) % n]);
      end
      if (kind != KIND_NO_CLEAR) push_item(OP_CLEAR, $urandom);
      foreach (arr[i]) begin
         if ($urandom_range(0, 19) == 0) push_item(OP_UNUSED, $urandom);
         push_item(OP_APPEND, arr[i]);
      end
      for (int s = 0; s < searches; s++) begin
         r = $urandom_range(0, 99);
         if (arr.size() == 0 || r < 30) begin
            tgt = $urandom;
         end else if (s == 0) begin
            tgt = arr[arr.size() - 1];
         end else if (s == 1) begin
            tgt = arr[0];
         end else if (r < 75) begin
            tgt = arr[$urandom_range(0, arr.size() - 1)];
         end else if (r < 90) begin
            tgt = arr[$urandom_range(0, arr.size() - 1)] + ($urandom_range(0, 1) ? 1 : -1);
         end else begin
            tgt = $urandom_range(0, 1) ? WORD_MIN : WORD_MAX;
         end
         if ($urandom_range(0, 19) == 0) push_item(OP_UNUSED, $urandom);
         push_item(OP_SEARCH, tgt);
      end
   endtask

   initial begin
      int seq;
      int r;
      int n;
      sb = new;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty array, extremes, unused opcode, clear then reuse
      push_item(OP_SEARCH, WORD_MIN);
      push_item(OP_UNUSED, 32'sd5);
      push_item(OP_CLEAR, '0);
      push_item(OP_APPEND, 32'sd5);
      push_item(OP_APPEND, 32'sd100);
      push_item(OP_APPEND, WORD_MAX);
      push_item(OP_APPEND, WORD_MIN);
      push_item(OP_APPEND, -32'sd7);
      push_item(OP_APPEND, 32'sd0);
      push_item(OP_SEARCH, WORD_MIN);
      push_item(OP_SEARCH, WORD_MAX);
      push_item(OP_SEARCH, 32'sd0);
      push_item(OP_SEARCH, 32'sd5);
      push_item(OP_SEARCH, 32'sd100);
      push_item(OP_SEARCH, -32'sd7);
      push_item(OP_SEARCH, 32'sd1);
      push_item(OP_SEARCH, 32'sd6);
      push_item(OP_SEARCH, -32'sd8);
      push_item(OP_UNUSED, WORD_MAX);
      push_item(OP_CLEAR, WORD_MAX);
      push_item(OP_SEARCH, 32'sd0);
      push_item(OP_APPEND, 32'sd42);
      push_item(OP_SEARCH, 32'sd42);
      push_item(OP_SEARCH, 32'sd41);

      seq = 0;
      while (sent < 1275) begin
         calm = ($urandom_range(0, 5) == 0);
         if (seq == 2) begin
            calm     = 1'b0;
            hold_req = 1'b1;
            run_sequence(12, KIND_ROTATED, 6);
         end else if (seq == 4) begin
            run_sequence(TB_DEPTH, KIND_ROTATED, 30);
            repeat (3) push_item(OP_APPEND, $urandom);
            repeat (4) push_item(OP_SEARCH, $urandom);
         end else begin
            r = $urandom_range(0, 99);
            if (r < 20) n = $urandom_range(0, 3);
            else if (r < 90) n = $urandom_range(4, 40);
            else n = $urandom_range(41, 200);
            r = $urandom_range(0, 99);
            if (r < 60) run_sequence(n, KIND_ROTATED, $urandom_range(1, 10));
            else if (r < 75) run_sequence(n, KIND_DENSE, $urandom_range(1, 10));
            else if (r < 88) run_sequence(n, KIND_UNSORTED, $urandom_range(1, 6));
            else run_sequence($urandom_range(0, 10), KIND_NO_CLEAR, $urandom_range(1, 6));
         end
         if (seq == 3 || $urandom_range(0, 4) == 0) wait_drained();
         seq++;
      end

      @(negedge clock);
      req_valid <= 1'b0;
      calm = 1'b1;
      wait_drained();
      repeat (40) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("rotated_sorted_array_search test passed");
      end else begin
         $display("rotated_sorted_array_search test failed");
      end
      $finish;
   end

endmodule
